// ===== design/fourier_series_wrench_generator_top_macros.svh =====
// Assertion macros shared by the wrench generator RTL
`ifndef FOURIER_SERIES_WRENCH_GENERATOR_TOP_MACROS_SVH
`define FOURIER_SERIES_WRENCH_GENERATOR_TOP_MACROS_SVH

// checked outside reset
`define FSWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define FSWG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fswg_pkg.sv =====
// Package: widths, codes, tables and arithmetic helpers of the wrench generator
`default_nettype none

package fswg_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int TRIG_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int TIME_W     = 32;
  localparam int FREQ_W     = 24;
  localparam int COEF_W     = 32;
  localparam int FORCE_W    = 32;
  localparam int TURN_W     = 32;
  localparam int PROD_W     = FREQ_W + TIME_W;
  localparam int ANG_W      = 32;
  localparam int XY_W       = 33;
  localparam int TERM_W     = COEF_W + TRIG_BITS;
  localparam int ACC_W      = TERM_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = XY_W'(64'sd652032874);

  localparam logic signed [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  localparam logic signed [XY_W:0] TRIG_HALF = (XY_W+1)'(64'sd1 <<< (30 - TRIG_BITS));
  localparam logic signed [XY_W:0] TRIG_MAX  = (XY_W+1)'((64'sd1 <<< (TRIG_BITS-1)) - 64'sd1);
  localparam logic signed [XY_W:0] TRIG_MIN  = (XY_W+1)'(-(64'sd1 <<< (TRIG_BITS-1)));

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (TRIG_BITS-2));
  localparam logic signed [ACC_W-1:0] FORCE_MAX  = ACC_W'((64'sd1 <<< (FORCE_W-1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] FORCE_MIN  = ACC_W'(-(64'sd1 <<< (FORCE_W-1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC   = 3'd0,
    CFG_COS1 = 3'd1,
    CFG_COS2 = 3'd2,
    CFG_SIN1 = 3'd3,
    CFG_SIN2 = 3'd4,
    CFG_FREQ = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    quad_t                    quad;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [ANG_W-1:0]  z;
  } cordic_lane_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] dc;
    logic signed [COEF_W-1:0] cos1;
    logic signed [COEF_W-1:0] cos2;
    logic signed [COEF_W-1:0] sin1;
    logic signed [COEF_W-1:0] sin2;
  } coef_set_t;

  function automatic cordic_lane_t cordic_init(input logic [PHASE_BITS-1:0] ph);
    logic [ANG_W-1:0] ang;
    cordic_lane_t     r;
    ang    = {ph, {(ANG_W-PHASE_BITS){1'b0}}};
    r.quad = quad_t'(ang[ANG_W-1 -: 2]);
    r.x    = CORDIC_GAIN_INV;
    r.y    = '0;
    r.z    = {2'b00, ang[ANG_W-3:0]};
    return r;
  endfunction

  function automatic cordic_lane_t cordic_step(input cordic_lane_t a,
                                               input logic [STEP_W-1:0] i);
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    cordic_lane_t           r;
    dx     = a.y >>> i;
    dy     = a.x >>> i;
    r.quad = a.quad;
    if (!a.z[ANG_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ATAN_TURNS[i];
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ATAN_TURNS[i];
    end
    return r;
  endfunction

  function automatic logic signed [XY_W-1:0] fold_cos(input cordic_lane_t a);
    logic signed [XY_W-1:0] r;
    case (a.quad)
      QUAD_0:  r = a.x;
      QUAD_1:  r = -a.y;
      QUAD_2:  r = -a.x;
      QUAD_3:  r = a.y;
      default: r = a.x;
    endcase
    return r;
  endfunction

  function automatic logic signed [XY_W-1:0] fold_sin(input cordic_lane_t a);
    logic signed [XY_W-1:0] r;
    case (a.quad)
      QUAD_0:  r = a.y;
      QUAD_1:  r = a.x;
      QUAD_2:  r = -a.y;
      QUAD_3:  r = -a.x;
      default: r = a.y;
    endcase
    return r;
  endfunction

  // Q2.30 to Q1.(TRIG_BITS-1), round half up, saturate
  function automatic trig_t to_trig(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] t;
    logic signed [XY_W:0] s;
    trig_t                r;
    t = (XY_W+1)'(v) + TRIG_HALF;
    s = t >>> (31 - TRIG_BITS);
    if (s > TRIG_MAX) begin
      r = TRIG_MAX[TRIG_BITS-1:0];
    end else if (s < TRIG_MIN) begin
      r = TRIG_MIN[TRIG_BITS-1:0];
    end else begin
      r = s[TRIG_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/fswg_in_if.sv =====
// Input channel: time stamp items
`default_nettype none

interface fswg_in_if;
  import fswg_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_now;

  modport source (output valid, output time_now, input ready);
  modport sink   (input valid, input time_now, output ready);
endinterface

`default_nettype wire

// ===== design/fswg_out_if.sv =====
// Output channel: force items
`default_nettype none

interface fswg_out_if;
  import fswg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_out;

  modport source (output valid, output force_out, input ready);
  modport sink   (input valid, input force_out, output ready);
endinterface

`default_nettype wire

// ===== design/fourier_series_wrench_generator_top.sv =====
// Top level: two-harmonic Fourier feed-forward force generator, one axis
//
// in_ch carries time stamps (unsigned Q16.16 seconds); out_ch returns one
// force item (signed Q16.16, saturated) per time stamp, in order.
// Coefficients and base frequency are written through cfg_we/cfg_idx/cfg_data
// by the user only while no item is in flight, which the block does not
// enforce; unknown indexes are ignored. Stages: phase multiply, 24 CORDIC
// iterations, fold/round, products, then two adder levels, the second with
// saturation. Throughput: one item per cycle while the skid is empty; every
// stage advances together on one enable. A one-item skid register at the
// output catches the item in the last stage when out_ch.ready is low; the
// pipeline then holds and in_ch.ready drops until the skid register empties.
// Nothing is lost or repeated on a stall. Reset (rst, synchronous) clears all
// valid bits, skid_full and the configuration registers to zero.
`default_nettype none

`include "fourier_series_wrench_generator_top_macros.svh"

module fourier_series_wrench_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fswg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fswg_pkg::CFG_DATA_W-1:0] cfg_data,
  fswg_in_if.sink                         in_ch,
  fswg_out_if.source                      out_ch
);
  import fswg_pkg::*;

  coef_set_t         coef;
  logic [FREQ_W-1:0] base_freq;

  logic                      en;
  logic                      ph_valid;
  logic [PHASE_BITS-1:0]     phase;
  logic                      cr_valid;
  cordic_lane_t [1:0]        lanes;
  logic                      last_valid;
  logic signed [FORCE_W-1:0] last_force;

  logic                      skid_full;
  logic signed [FORCE_W-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef      <= '0;
      base_freq <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DC:   coef.dc   <= $signed(cfg_data[COEF_W-1:0]);
        CFG_COS1: coef.cos1 <= $signed(cfg_data[COEF_W-1:0]);
        CFG_COS2: coef.cos2 <= $signed(cfg_data[COEF_W-1:0]);
        CFG_SIN1: coef.sin1 <= $signed(cfg_data[COEF_W-1:0]);
        CFG_SIN2: coef.sin2 <= $signed(cfg_data[COEF_W-1:0]);
        CFG_FREQ: base_freq <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !skid_full;
  assign in_ch.ready = en;

  fswg_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .time_now  (in_ch.time_now),
    .base_freq (base_freq),
    .out_valid (ph_valid),
    .phase     (phase)
  );

  fswg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ph_valid),
    .phase     (phase),
    .out_valid (cr_valid),
    .lanes     (lanes)
  );

  fswg_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cr_valid),
    .lanes     (lanes),
    .coef      (coef),
    .out_valid (last_valid),
    .force_out (last_force)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ch.ready) begin
        skid_full <= 1'b0;
      end
    end else if (last_valid && !out_ch.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_data <= last_force;
    end
  end

  assign out_ch.valid     = skid_full || last_valid;
  assign out_ch.force_out = skid_full ? skid_data : last_force;

  `FSWG_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !out_ch.valid, "output valid after reset")
  `FSWG_ASSERT(a_skid_holds, skid_full && !out_ch.ready |=> skid_full && $stable(skid_data), "skid item lost under stall")
  `FSWG_ASSERT(a_skid_fill, !skid_full && last_valid && !out_ch.ready |=> skid_full && (skid_data == $past(last_force)), "stalled item not caught")

endmodule

`default_nettype wire

// ===== design/fswg_phase.sv =====
// Phase stage: frequency times time, fraction of a turn
`default_nettype none

module fswg_phase (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [fswg_pkg::TIME_W-1:0]     time_now,
  input  logic [fswg_pkg::FREQ_W-1:0]     base_freq,
  output logic                            out_valid,
  output logic [fswg_pkg::PHASE_BITS-1:0] phase
);
  import fswg_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(base_freq) * PROD_W'(time_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase <= prod[TURN_W-1 -: PHASE_BITS];
    end
  end

endmodule

`default_nettype wire

// ===== design/fswg_cordic.sv =====
// CORDIC rotator: one iteration per stage, lanes for the base and double angle
`default_nettype none

module fswg_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [fswg_pkg::PHASE_BITS-1:0] phase,
  output logic                            out_valid,
  output fswg_pkg::cordic_lane_t [1:0]    lanes
);
  import fswg_pkg::*;

  cordic_lane_t [1:0]      init;
  cordic_lane_t [1:0]      stage_q [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] vld;

  assign init[0] = cordic_init(phase);
  assign init[1] = cordic_init({phase[PHASE_BITS-2:0], 1'b0});

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
    cordic_lane_t [1:0] src;
    if (g == 0) begin : g_first
      assign src = init;
    end else begin : g_rest
      assign src = stage_q[g-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stage_q[g][0] <= cordic_step(src[0], STEP_W'(g));
        stage_q[g][1] <= cordic_step(src[1], STEP_W'(g));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CORDIC_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld[CORDIC_STEPS-1];
  assign lanes     = stage_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== design/fswg_sum.sv =====
// Series sum: quadrant fold, trig rounding, products, adder tree, saturation
`default_nettype none

module fswg_sum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  fswg_pkg::cordic_lane_t [1:0]       lanes,
  input  fswg_pkg::coef_set_t                coef,
  output logic                               out_valid,
  output logic signed [fswg_pkg::FORCE_W-1:0] force_out
);
  import fswg_pkg::*;

  logic [3:0] vld;

  trig_t c1, s1, c2, s2;

  logic signed [TERM_W-1:0] m_dc, m_c1, m_c2, m_s1, m_s2;
  logic signed [ACC_W-1:0]  sum_a, sum_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [FORCE_W-1:0] force_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign acc    = sum_a + sum_b + ROUND_HALF;
  assign scaled = acc >>> (TRIG_BITS-1);

  always_comb begin
    if (scaled > FORCE_MAX) begin
      force_next = FORCE_MAX[FORCE_W-1:0];
    end else if (scaled < FORCE_MIN) begin
      force_next = FORCE_MIN[FORCE_W-1:0];
    end else begin
      force_next = scaled[FORCE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= to_trig(fold_cos(lanes[0]));
      s1 <= to_trig(fold_sin(lanes[0]));
      c2 <= to_trig(fold_cos(lanes[1]));
      s2 <= to_trig(fold_sin(lanes[1]));

      m_dc <= TERM_W'(coef.dc) <<< (TRIG_BITS-2);
      m_c1 <= TERM_W'(coef.cos1) * TERM_W'(c1);
      m_c2 <= TERM_W'(coef.cos2) * TERM_W'(c2);
      m_s1 <= TERM_W'(coef.sin1) * TERM_W'(s1);
      m_s2 <= TERM_W'(coef.sin2) * TERM_W'(s2);

      sum_a <= ACC_W'(m_dc) + ACC_W'(m_c1) + ACC_W'(m_c2);
      sum_b <= ACC_W'(m_s1) + ACC_W'(m_s2);

      force_out <= force_next;
    end
  end

  assign out_valid = vld[3];

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the two-harmonic Fourier force generator: CORDIC predictor vs DUT
`timescale 1ns / 100ps

module tb_top;
  import fswg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int  LONG_HOLD    = 300;
  localparam int  PHASES       = 8;
  localparam int  PHASE_ITEMS  = 250;
  localparam int  TAIL_CYCLES  = 40;
  localparam int  MAX_REPORTS  = 100;
  localparam longint CORDIC_SCALE = 652032874;

  localparam longint ARC_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [COEF_W-1:0] dc;
    logic [COEF_W-1:0] cos1;
    logic [COEF_W-1:0] cos2;
    logic [COEF_W-1:0] sin1;
    logic [COEF_W-1:0] sin2;
    logic [FREQ_W-1:0] freq;
  } wave_cfg_t;

  typedef struct packed {
    wave_cfg_t          wave;
    logic [TIME_W-1:0]  t;
    logic               known;
    logic [FORCE_W-1:0] force_exp;
  } shot_t;

  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_ONE = 32'h0001_0000;

  localparam wave_cfg_t W_ZERO   = '0;
  localparam wave_cfg_t W_DC_HI  = '{C_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0};
  localparam wave_cfg_t W_DC_LO  = '{C_MIN, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0};
  localparam wave_cfg_t W_COS1   = '{32'h0, C_ONE, 32'h0, 32'h0, 32'h0, 24'h0};
  localparam wave_cfg_t W_COS2   = '{32'h0, 32'h0, C_ONE, 32'h0, 32'h0, 24'h0};
  localparam wave_cfg_t W_SAT_HI = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 24'h0};
  localparam wave_cfg_t W_SAT_LO = '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 24'h0};
  localparam wave_cfg_t W_UNIT   = '{C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, 24'h01_0000};
  localparam wave_cfg_t W_FMAX   = '{32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000,
                                     32'h0002_0000, 32'hFFFE_8000, 24'hFF_FFFF};
  localparam wave_cfg_t W_FMIN   = '{32'h0, C_MIN, 32'h0, C_MAX, C_MIN, 24'h00_0001};

  // cosine of zero rounds to the top Q1 code, so 1.0 * cos(0) gives 65534 LSBs
  localparam shot_t SHOTS [22] = '{
    '{W_ZERO,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{W_ZERO,   32'h0000_0000, 1'b1, 32'h0000_0000},
    '{W_DC_HI,  32'h1234_5678, 1'b1, 32'h4000_0000},
    '{W_DC_LO,  32'h0000_0000, 1'b1, 32'hC000_0000},
    '{W_COS1,   32'hFFFF_FFFF, 1'b1, 32'h0000_FFFE},
    '{W_COS2,   32'h8000_0001, 1'b1, 32'h0000_FFFE},
    '{W_SAT_HI, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    '{W_SAT_LO, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    '{W_UNIT,   32'h0000_0000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_2000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_4000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_6000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_8000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_A000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_C000, 1'b0, 32'h0},
    '{W_UNIT,   32'h0000_E000, 1'b0, 32'h0},
    '{W_FMAX,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{W_FMAX,   32'h0000_0001, 1'b0, 32'h0},
    '{W_FMAX,   32'h8000_0000, 1'b0, 32'h0},
    '{W_FMAX,   32'h0000_FFFF, 1'b0, 32'h0},
    '{W_FMIN,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{W_FMIN,   32'h0001_0000, 1'b0, 32'h0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  fswg_in_if  in_ch ();
  fswg_out_if out_ch ();

  fourier_series_wrench_generator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  wave_cfg_t          wave_now = '0;
  logic [FORCE_W-1:0] force_due [$];
  int                 mismatches = 0;
  bit                 steady_flow = 1'b0;
  bit                 hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("fourier_series_wrench_generator_top: mismatch");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Q2.30 to Q1.(TRIG_BITS-1), round half up, clamp
  function automatic longint q1_round(input longint v);
    longint r;
    longint top;
    top = (longint'(1) <<< (TRIG_BITS - 1));
    r = (v + (longint'(1) <<< (30 - TRIG_BITS))) >>> (31 - TRIG_BITS);
    if (r > top - 1) r = top - 1;
    if (r < -top) r = -top;
    return r;
  endfunction

  function automatic void turn_trig(input logic [PHASE_BITS-1:0] ph,
                                    output longint c, output longint s);
    logic [31:0] ang;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      cx;
    longint      sy;
    ang = {ph, {(32 - PHASE_BITS){1'b0}}};
    z = longint'(ang[29:0]);
    x = CORDIC_SCALE;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ARC_TURNS[i];
      end
    end
    case (quad_t'(ang[31:30]))
      QUAD_0: begin cx = x;  sy = y;  end
      QUAD_1: begin cx = -y; sy = x;  end
      QUAD_2: begin cx = -x; sy = -y; end
      default: begin cx = y; sy = -x; end
    endcase
    c = q1_round(cx);
    s = q1_round(sy);
  endfunction

  function automatic logic [FORCE_W-1:0] predict_force(input logic [TIME_W-1:0] t);
    logic [63:0]           prod;
    logic [PHASE_BITS-1:0] ph1;
    logic [PHASE_BITS-1:0] ph2;
    longint                c1, s1, c2, s2, acc, r;
    prod = 64'(wave_now.freq) * 64'(t);
    ph1  = prod[31 -: PHASE_BITS];
    ph2  = {ph1[PHASE_BITS-2:0], 1'b0};
    turn_trig(ph1, c1, s1);
    turn_trig(ph2, c2, s2);
    acc = longint'($signed(wave_now.dc)) * (longint'(1) <<< (TRIG_BITS - 2));
    acc += longint'($signed(wave_now.cos1)) * c1;
    acc += longint'($signed(wave_now.cos2)) * c2;
    acc += longint'($signed(wave_now.sin1)) * s1;
    acc += longint'($signed(wave_now.sin2)) * s2;
    r = (acc + (longint'(1) <<< (TRIG_BITS - 2))) >>> (TRIG_BITS - 1);
    if (r > longint'(32'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    if (r < longint'(32'sh8000_0000)) r = 32'sh8000_0000;
    return r[FORCE_W-1:0];
  endfunction

  function automatic logic [31:0] random_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return C_MAX;
    if (r == 2) return C_MIN;
    if (r < 5) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    return $urandom;
  endfunction

  function automatic wave_cfg_t random_wave();
    wave_cfg_t w;
    int        r;
    w.dc   = random_coef();
    w.cos1 = random_coef();
    w.cos2 = random_coef();
    w.sin1 = random_coef();
    w.sin2 = random_coef();
    r = $urandom_range(0, 9);
    if (r == 0) w.freq = '0;
    else if (r == 1) w.freq = '1;
    else if (r < 6) w.freq = $urandom_range(1, 24'h03_FFFF);
    else w.freq = $urandom;
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] random_time();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? '1 : '0;
    if (r < 3) return $urandom_range(0, 32'h0004_0000);
    return $urandom;
  endfunction

  // holds the enable high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_DC:   wave_now.dc   = data;
      CFG_COS1: wave_now.cos1 = data;
      CFG_COS2: wave_now.cos2 = data;
      CFG_SIN1: wave_now.sin1 = data;
      CFG_SIN2: wave_now.sin2 = data;
      CFG_FREQ: wave_now.freq = data[FREQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_wave(input wave_cfg_t w);
    write_reg(CFG_DC,   w.dc);
    write_reg(CFG_COS1, w.cos1);
    write_reg(CFG_COS2, w.cos2);
    write_reg(CFG_SIN1, w.sin1);
    write_reg(CFG_SIN2, w.sin2);
    write_reg(CFG_FREQ, {8'($urandom), w.freq});
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (force_due.size() != 0);
  endtask

  task automatic offer_time(input logic [TIME_W-1:0] t, input logic known,
                            input logic [FORCE_W-1:0] force_exp);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.time_now <= t;
    do @(posedge clk); while (!in_ch.ready);
    force_due.push_back(known ? force_exp : predict_force(t));
    gap = steady_flow ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_out
    logic [FORCE_W-1:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (force_due.size() == 0) begin
        note_mismatch("unexpected item", 'x, out_ch.force_out);
      end else begin
        want = force_due.pop_front();
        if (out_ch.force_out !== want) note_mismatch("force_out", want, out_ch.force_out);
      end
    end
  end

  initial begin : sink_side
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (steady_flow || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  initial begin : source_side
    wave_cfg_t w;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_DC;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.time_now <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first rows run on the reset register values
    for (int k = 0; k < $size(SHOTS); k++) begin
      if (SHOTS[k].wave != wave_now) begin
        drain_pipe();
        program_wave(SHOTS[k].wave);
      end
      offer_time(SHOTS[k].t, SHOTS[k].known, SHOTS[k].force_exp);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_pipe();
      if (p == 6) w = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 24'hFF_FFFF};
      else if (p == 7) w = '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 24'($urandom_range(1, 255))};
      else w = random_wave();
      program_wave(w);
      steady_flow = (p == 1 || p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 60) hold_req = 1'b1;
        if (p == 5 && n == PHASE_ITEMS / 2) drain_pipe();
        offer_time(random_time(), 1'b0, '0);
      end
    end

    steady_flow = 1'b0;
    drain_pipe();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && force_due.size() == 0) begin
      $display("fourier_series_wrench_generator_top: match");
    end else begin
      $display("fourier_series_wrench_generator_top: mismatch");
    end
    $finish;
  end

endmodule
